>>> rtl/core/fldec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fldec_pkg
// Shared types and constants for the four-line debounce and edge counter.
// ----------------------------------------------------------------------------
package fldec_pkg;

    localparam int LINES_DEF  = 4;
    localparam int MAX_LINES  = 8;
    localparam int PIN_W      = 4;
    localparam int TIME_W     = 32;
    localparam int CNT_W      = 32;
    localparam int CHAN_W     = 8;
    localparam int DEB_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [PIN_W-1:0] VALID_MASK = 4'h F;
    localparam logic [DEB_W-1:0] DEB_RESET  = 16'd20;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH = 1'd1;

    typedef enum logic [1:0] {
        REQ_PIN     = 2'd0,
        REQ_POLL    = 2'd1,
        REQ_CONSUME = 2'd2,
        REQ_INIT    = 2'd3
    } t_req_kind;

    typedef struct packed {
        t_req_kind          kind;
        logic [PIN_W-1:0]   pins;
        logic               line_hit;
        logic [TIME_W-1:0]  now_ms;
        logic [CHAN_W-1:0]  chan;
    } t_req;

    typedef struct packed {
        logic [PIN_W-1:0]   raw_lines;
        logic [PIN_W-1:0]   stable_bits;
        logic [PIN_W-1:0]   chg_flags;
        logic [CNT_W-1:0]   edge_count;
    } t_result;

    typedef struct packed {
        logic [DEB_W-1:0]   debounce_ms;
        logic               active_high;
    } t_cfg;

endpackage

>>> rtl/core/four_line_debounce_edge_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_line_debounce_edge_counter
// Debounced four-line input block with per-line toggle counters.
// ----------------------------------------------------------------------------
// Each request is captured in an input register, then the line state,
// debounce step and counters update in one pass and the result lands in an
// output register. One request per cycle is sustained while the result side
// does not stall; the only loop is the state update of that single pass.
// Output stall backs up through the input register, which can still take one
// request while a finished result waits. Write configuration only while idle.
// ----------------------------------------------------------------------------
module four_line_debounce_edge_counter #(
    parameter int LINES = fldec_pkg::LINES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_req_type,
    input  logic [fldec_pkg::PIN_W-1:0]        i_pin_levels,
    input  logic                               i_line_hit,
    input  logic [fldec_pkg::TIME_W-1:0]       i_now_ms,
    input  logic [fldec_pkg::CHAN_W-1:0]       i_query_channel,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [fldec_pkg::PIN_W-1:0]        o_raw_lines,
    output logic [fldec_pkg::PIN_W-1:0]        o_stable_bits,
    output logic [fldec_pkg::PIN_W-1:0]        o_chg_flags,
    output logic [fldec_pkg::CNT_W-1:0]        o_edge_count,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fldec_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fldec_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fldec_pkg::*;

    localparam logic [MAX_LINES-1:0] FULL_MASK =
        MAX_LINES'((16'd1 << LINES) - 16'd1);
    localparam logic [PIN_W-1:0] LMASK = FULL_MASK[PIN_W-1:0] & VALID_MASK;

    logic    r_in_valid;
    t_req    r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result core_res;
    t_cfg    cfg;
    logic    adv;
    logic    accept_in;

    assign o_cfg_ready = 1'b1;

    fldec_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // advance the held request when the result slot frees up
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign accept_in  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept_in) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in.kind     <= t_req_kind'(i_req_type);
            r_in.pins     <= i_pin_levels;
            r_in.line_hit <= i_line_hit;
            r_in.now_ms   <= i_now_ms;
            r_in.chan     <= i_query_channel;
        end
    end

    fldec_core #(
        .LINES (LINES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (adv),
        .i_req   (r_in),
        .i_cfg   (cfg),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_raw_lines   = r_out.raw_lines;
    assign o_stable_bits = r_out.stable_bits;
    assign o_chg_flags   = r_out.chg_flags;
    assign o_edge_count  = r_out.edge_count;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_valid && !r_out_valid)
        else $error("pipeline not empty after reset");

    a_adv_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> o_out_valid)
        else $error("advanced request produced no result");

    a_init_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in.kind == REQ_INIT |=>
            o_chg_flags == '0 && o_stable_bits == o_raw_lines &&
            o_edge_count == '0)
        else $error("init result not cleared");

    a_unused_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_raw_lines & ~LMASK) == '0 &&
                        (o_stable_bits & ~LMASK) == '0)
        else $error("unused line bit set");

endmodule

>>> rtl/core/fldec_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fldec_cfg
// Configuration registers: debounce time and pin polarity.
// ----------------------------------------------------------------------------
module fldec_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr,
    input  logic [fldec_pkg::CFG_IDX_W-1:0]    i_index,
    input  logic [fldec_pkg::CFG_DATA_W-1:0]   i_data,
    output fldec_pkg::t_cfg                    o_cfg
);
    import fldec_pkg::*;

    logic [DEB_W-1:0] r_debounce_ms;
    logic             r_active_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= DEB_RESET;
            r_active_high <= 1'b1;
        end else if (i_wr) begin
            case (i_index)
                CFG_DEBOUNCE_MS: r_debounce_ms <= i_data[DEB_W-1:0];
                CFG_ACTIVE_HIGH: r_active_high <= i_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg.debounce_ms = r_debounce_ms;
    assign o_cfg.active_high = r_active_high;

endmodule

>>> rtl/core/fldec_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fldec_core
// Line state, debounce step and toggle counters; result of one request.
// ----------------------------------------------------------------------------
module fldec_core #(
    parameter int LINES = fldec_pkg::LINES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  fldec_pkg::t_req     i_req,
    input  fldec_pkg::t_cfg     i_cfg,
    output fldec_pkg::t_result  o_res
);
    import fldec_pkg::*;

    localparam logic [MAX_LINES-1:0] FULL_MASK =
        MAX_LINES'((16'd1 << LINES) - 16'd1);
    localparam logic [PIN_W-1:0] LMASK = FULL_MASK[PIN_W-1:0] & VALID_MASK;

    logic [PIN_W-1:0]  r_raw, n_raw;
    logic [PIN_W-1:0]  r_cand, n_cand;
    logic [PIN_W-1:0]  r_stable, n_stable;
    logic [PIN_W-1:0]  r_flags, n_flags;
    logic [TIME_W-1:0] r_cand_time, n_cand_time;
    logic [CNT_W-1:0]  r_counts [LINES];
    logic [CNT_W-1:0]  n_counts [LINES];

    logic [PIN_W-1:0]     fresh;
    logic [PIN_W-1:0]     diff;
    logic [MAX_LINES-1:0] diff_ext;
    logic [TIME_W-1:0]    held;
    logic [PIN_W-1:0]     report_flags;
    logic [CNT_W-1:0]     count;

    assign fresh    = (i_cfg.active_high ? i_req.pins : ~i_req.pins) & LMASK;
    assign diff     = (r_raw ^ fresh) & LMASK;
    assign diff_ext = {{(MAX_LINES-PIN_W){1'b0}}, diff};
    assign held     = i_req.now_ms - r_cand_time;

    always_comb begin
        n_raw        = r_raw;
        n_cand       = r_cand;
        n_stable     = r_stable;
        n_flags      = r_flags;
        n_cand_time  = r_cand_time;
        report_flags = r_flags;
        for (int i = 0; i < LINES; i++) begin
            n_counts[i] = r_counts[i];
        end
        case (i_req.kind)
            REQ_PIN: begin
                if (i_req.line_hit) begin
                    n_raw = fresh;
                    for (int i = 0; i < LINES; i++) begin
                        n_counts[i] = r_counts[i] + CNT_W'(diff_ext[i]);
                    end
                end
            end
            REQ_POLL: begin
                // A new raw value only restarts the window; promotion waits
                if (r_raw != r_cand) begin
                    n_cand      = r_raw;
                    n_cand_time = i_req.now_ms;
                end else if (r_raw != r_stable &&
                             held >= TIME_W'(i_cfg.debounce_ms)) begin
                    n_stable = r_raw;
                    n_flags  = (r_flags | (r_stable ^ r_raw)) & VALID_MASK;
                end
                report_flags = n_flags;
            end
            REQ_CONSUME: begin
                n_flags = '0;
            end
            REQ_INIT: begin
                n_raw        = fresh;
                n_cand       = fresh;
                n_stable     = fresh;
                n_flags      = '0;
                n_cand_time  = i_req.now_ms;
                report_flags = '0;
                for (int i = 0; i < LINES; i++) begin
                    n_counts[i] = '0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        count = '0;
        for (int i = 0; i < LINES; i++) begin
            if (i_req.chan == CHAN_W'(i)) begin
                count = n_counts[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw       <= '0;
            r_cand      <= '0;
            r_stable    <= '0;
            r_flags     <= '0;
            r_cand_time <= '0;
            for (int i = 0; i < LINES; i++) begin
                r_counts[i] <= '0;
            end
        end else if (i_fire) begin
            r_raw       <= n_raw;
            r_cand      <= n_cand;
            r_stable    <= n_stable;
            r_flags     <= n_flags;
            r_cand_time <= n_cand_time;
            for (int i = 0; i < LINES; i++) begin
                r_counts[i] <= n_counts[i];
            end
        end
    end

    assign o_res.raw_lines   = n_raw;
    assign o_res.stable_bits = n_stable;
    assign o_res.chg_flags   = report_flags;
    assign o_res.edge_count  = count;

endmodule

>>> sim/tb_four_line_debounce_edge_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_line_debounce_edge_counter
// Self-checking bench for the four-line debounce and edge counter.
// ----------------------------------------------------------------------------
// A directed pass covers init, ignored and real pin events, debounce below,
// at and across the time wrap, zero and maximum debounce, active-low pins,
// consume twice and out-of-range channels. Random phases then run mostly
// well-formed request streams with a monotonic clock under several register
// settings, plus some noise. An in-bench predictor tracks line state, and
// every result is compared field by field with the oldest expected one. The
// sender works in bursts and the receiver stalls on its own pattern,
// including two long hold-offs that back the block up.
// ----------------------------------------------------------------------------
module tb_four_line_debounce_edge_counter;
    import fldec_pkg::*;

    localparam int NUM_LINES  = LINES_DEF;
    localparam int MAX_PRINTS = 40;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [1:0]             i_req_type = REQ_PIN;
    logic [PIN_W-1:0]       i_pin_levels = '0;
    logic                   i_line_hit = 1'b0;
    logic [TIME_W-1:0]      i_now_ms = '0;
    logic [CHAN_W-1:0]      i_query_channel = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [PIN_W-1:0]       o_raw_lines;
    logic [PIN_W-1:0]       o_stable_bits;
    logic [PIN_W-1:0]       o_chg_flags;
    logic [CNT_W-1:0]       o_edge_count;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = CFG_DEBOUNCE_MS;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    four_line_debounce_edge_counter #(
        .LINES(NUM_LINES)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_pin_levels   (i_pin_levels),
        .i_line_hit     (i_line_hit),
        .i_now_ms       (i_now_ms),
        .i_query_channel(i_query_channel),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_raw_lines    (o_raw_lines),
        .o_stable_bits  (o_stable_bits),
        .o_chg_flags    (o_chg_flags),
        .o_edge_count   (o_edge_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted line state and register copies
    logic [PIN_W-1:0]   line_raw;
    logic [PIN_W-1:0]   line_cand;
    logic [PIN_W-1:0]   line_stable;
    logic [PIN_W-1:0]   line_flags;
    logic [TIME_W-1:0]  cand_stamp;
    logic [CNT_W-1:0]   toggle_cnt [NUM_LINES];
    logic [DEB_W-1:0]   cfg_debounce;
    logic               cfg_active_high;
    t_result            expected_results[$];

    // Stimulus state
    logic [TIME_W-1:0]  ms_now = '0;
    logic [PIN_W-1:0]   last_pins = '0;
    int                 phase_debounce = DEB_RESET;
    int                 burst_left = 0;
    int                 hold_request = 0;

    // Receiver stall pattern
    int                 hold_left = 0;
    int                 stall_mode = 0;
    int                 mode_left = 0;

    // Bookkeeping
    int                 err_count = 0;
    int                 results_checked = 0;
    int                 promotions = 0;
    int                 in_stall_cycles = 0;
    int                 kind_count [4] = '{0, 0, 0, 0};

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("%0t ERROR: %s", $time, msg);
    endtask

    function automatic logic [PIN_W-1:0] active_lines(input logic [PIN_W-1:0] pins);
        logic [PIN_W-1:0] p;
        p = cfg_active_high ? pins : ~pins;
        return p & VALID_MASK;
    endfunction

    task automatic clear_line_state();
        line_raw    = '0;
        line_cand   = '0;
        line_stable = '0;
        line_flags  = '0;
        cand_stamp  = '0;
        for (int n = 0; n < NUM_LINES; n++)
            toggle_cnt[n] = '0;
    endtask

    task automatic predict_request(input t_req rq, output t_result res);
        logic [PIN_W-1:0]   fresh;
        logic [PIN_W-1:0]   flip;
        logic [PIN_W-1:0]   flags_out;
        logic [TIME_W-1:0]  held_ms;
        fresh = active_lines(rq.pins);
        flags_out = line_flags;
        case (rq.kind)
            REQ_PIN: begin
                if (rq.line_hit) begin
                    flip = line_raw ^ fresh;
                    line_raw = fresh;
                    for (int n = 0; n < NUM_LINES; n++)
                        if (flip[n])
                            toggle_cnt[n] = toggle_cnt[n] + 1;
                end
                flags_out = line_flags;
            end
            REQ_POLL: begin
                held_ms = rq.now_ms - cand_stamp;
                if (line_raw != line_cand) begin
                    // restart the hold window
                    line_cand  = line_raw;
                    cand_stamp = rq.now_ms;
                end else if (line_raw != line_stable &&
                             held_ms >= TIME_W'(cfg_debounce)) begin
                    flip        = (line_stable ^ line_raw) & VALID_MASK;
                    line_stable = line_raw;
                    line_flags  = (line_flags | flip) & VALID_MASK;
                    promotions++;
                end
                flags_out = line_flags;
            end
            REQ_CONSUME: begin
                flags_out  = line_flags;
                line_flags = '0;
            end
            default: begin
                line_raw    = fresh;
                line_cand   = fresh;
                line_stable = fresh;
                line_flags  = '0;
                cand_stamp  = rq.now_ms;
                for (int n = 0; n < NUM_LINES; n++)
                    toggle_cnt[n] = '0;
                flags_out = '0;
            end
        endcase
        res.raw_lines   = line_raw;
        res.stable_bits = line_stable;
        res.chg_flags   = flags_out;
        res.edge_count  = '0;
        if (rq.chan < NUM_LINES)
            res.edge_count = toggle_cnt[rq.chan];
    endtask

    task automatic compare_result(input t_result exp_res, input t_result got_res);
        if (got_res.raw_lines !== exp_res.raw_lines)
            report_mismatch($sformatf("raw lines expected %h got %h",
                                      exp_res.raw_lines, got_res.raw_lines));
        if (got_res.stable_bits !== exp_res.stable_bits)
            report_mismatch($sformatf("stable_bits expected %h got %h",
                                      exp_res.stable_bits, got_res.stable_bits));
        if (got_res.chg_flags !== exp_res.chg_flags)
            report_mismatch($sformatf("change flags expected %h got %h",
                                      exp_res.chg_flags, got_res.chg_flags));
        if (got_res.edge_count !== exp_res.edge_count)
            report_mismatch($sformatf("edge_count expected %0d got %0d",
                                      exp_res.edge_count, got_res.edge_count));
    endtask

    // Predict on every accepted request, check every accepted result
    always @(posedge i_clk) begin : monitor
        t_req       rq;
        t_result    exp_res;
        t_result    got_res;
        if (!i_rst_n) begin
            clear_line_state();
            cfg_debounce    = DEB_RESET;
            cfg_active_high = 1'b1;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_DEBOUNCE_MS)
                    cfg_debounce = i_cfg_data[DEB_W-1:0];
                else
                    cfg_active_high = i_cfg_data[0];
            end
            if (i_in_valid && o_in_stall)
                in_stall_cycles++;
            if (i_in_valid && !o_in_stall) begin
                rq.kind     = t_req_kind'(i_req_type);
                rq.pins     = i_pin_levels;
                rq.line_hit = i_line_hit;
                rq.now_ms   = i_now_ms;
                rq.chan     = i_query_channel;
                kind_count[i_req_type]++;
                predict_request(rq, exp_res);
                expected_results.push_back(exp_res);
            end
            if (o_out_valid && !i_out_stall) begin
                got_res.raw_lines   = o_raw_lines;
                got_res.stable_bits = o_stable_bits;
                got_res.chg_flags   = o_chg_flags;
                got_res.edge_count  = o_edge_count;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request pending");
                end else begin
                    exp_res = expected_results.pop_front();
                    compare_result(exp_res, got_res);
                    results_checked++;
                end
            end
        end
    end

    // Result-side stall: long hold-offs on request, otherwise changing patterns
    always @(posedge i_clk) begin : out_stall_gen
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 150);
            end
            mode_left--;
            case (stall_mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 9) < 3);
                2:       i_out_stall <= (mode_left % 4 == 0);
                default: i_out_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    // Offer one request and hold it until taken; valid stays high afterwards
    task automatic send_req(input t_req_kind kind, input logic [PIN_W-1:0] pins,
                            input logic hit, input logic [TIME_W-1:0] now,
                            input logic [CHAN_W-1:0] chan);
        i_in_valid      <= 1'b1;
        i_req_type      <= kind;
        i_pin_levels    <= pins;
        i_line_hit      <= hit;
        i_now_ms        <= now;
        i_query_channel <= chan;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    task automatic send_paced(input t_req rq);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        send_req(rq.kind, rq.pins, rq.line_hit, rq.now_ms, rq.chan);
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (expected_results.size() != 0);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly well-formed traffic on an advancing clock, with some noise
    function automatic t_req next_random_req();
        t_req rq;
        int   pick;
        pick = $urandom_range(0, 99);
        ms_now = ms_now + $urandom_range(0, phase_debounce / 2 + 4);
        rq.kind     = REQ_POLL;
        rq.pins     = PIN_W'($urandom_range(0, 15));
        rq.line_hit = 1'b1;
        rq.now_ms   = ms_now;
        rq.chan     = CHAN_W'($urandom_range(0, NUM_LINES - 1));
        if ($urandom_range(0, 7) == 0)
            rq.chan = CHAN_W'($urandom_range(0, 255));
        if (pick < 40) begin
            rq.kind = REQ_PIN;
            if ($urandom_range(0, 4) == 0)
                last_pins = PIN_W'($urandom_range(0, 15));
            rq.pins = last_pins;
            if ($urandom_range(0, 9) == 0)
                rq.line_hit = 1'b0;
            else
                rq.line_hit = 1'b1;
        end else if (pick < 85) begin
            rq.kind = REQ_POLL;
        end else if (pick < 95) begin
            rq.kind = REQ_CONSUME;
        end else if (pick < 98) begin
            rq.kind = REQ_INIT;
            last_pins = rq.pins;
        end else begin
            rq.kind     = t_req_kind'($urandom_range(0, 3));
            rq.line_hit = 1'($urandom_range(0, 1));
            rq.now_ms   = $urandom();
        end
        return rq;
    endfunction

    task automatic test_directed();
        send_req(REQ_INIT,    4'h5, 1'b1, 32'd100, 8'd0);
        send_req(REQ_PIN,     4'hF, 1'b1, 32'd150, 8'd1);
        send_req(REQ_PIN,     4'h0, 1'b0, 32'd160, 8'd3);   // ignored event
        send_req(REQ_POLL,    4'h0, 1'b1, 32'd200, 8'd3);   // candidate restart
        send_req(REQ_POLL,    4'h0, 1'b1, 32'd219, 8'd0);   // one short of debounce
        send_req(REQ_POLL,    4'h0, 1'b1, 32'd220, 8'd1);   // promote
        send_req(REQ_CONSUME, 4'h0, 1'b1, 32'd221, 8'd4);
        send_req(REQ_CONSUME, 4'h0, 1'b1, 32'd222, 8'd255);
        send_req(REQ_PIN,     4'h0, 1'b1, 32'd0,   8'd2);
        // hold window spanning the clock wrap
        send_req(REQ_INIT,    4'h0, 1'b1, 32'hFFFF_FFF0, 8'd3);
        send_req(REQ_PIN,     4'h9, 1'b1, 32'hFFFF_FFF4, 8'd0);
        send_req(REQ_POLL,    4'h0, 1'b1, 32'hFFFF_FFF8, 8'd0);
        send_req(REQ_POLL,    4'hF, 1'b1, 32'hFFFF_FFFF, 8'd3);
        send_req(REQ_POLL,    4'h0, 1'b1, 32'h0000_000C, 8'd0);
        send_req(REQ_CONSUME, 4'hF, 1'b0, 32'h0000_000D, 8'd3);
        send_req(REQ_POLL,    4'h0, 1'b1, 32'h0000_0000, 8'd2);
    endtask

    task automatic test_cfg_extremes();
        // zero debounce with active-low pins
        wait_drain();
        write_cfg(CFG_DEBOUNCE_MS, 16'd0);
        write_cfg(CFG_ACTIVE_HIGH, 16'hFFFE);
        send_req(REQ_INIT,    4'hF, 1'b1, 32'd5, 8'd0);
        send_req(REQ_PIN,     4'h6, 1'b1, 32'd5, 8'd3);
        send_req(REQ_POLL,    4'h0, 1'b1, 32'd5, 8'd0);
        send_req(REQ_POLL,    4'h0, 1'b1, 32'd5, 8'd1);
        // longest debounce, active-high again
        wait_drain();
        write_cfg(CFG_DEBOUNCE_MS, 16'hFFFF);
        write_cfg(CFG_ACTIVE_HIGH, 16'h0001);
        send_req(REQ_PIN,     4'hF, 1'b1, 32'd1000, 8'd2);
        send_req(REQ_POLL,    4'h0, 1'b1, 32'd1000, 8'd0);
        send_req(REQ_POLL,    4'h0, 1'b1, 32'd1000 + 32'd65534, 8'd1);
        send_req(REQ_POLL,    4'h0, 1'b1, 32'd1000 + 32'd65535, 8'd2);
        send_req(REQ_CONSUME, 4'h0, 1'b1, 32'd1000 + 32'd65536, 8'd0);
    endtask

    task automatic test_random_phase(input int n_items, input logic [DEB_W-1:0] deb,
                                     input logic polarity);
        logic [CFG_DATA_W-1:0] cfg_word;
        wait_drain();
        write_cfg(CFG_DEBOUNCE_MS, deb);
        cfg_word    = CFG_DATA_W'($urandom());
        cfg_word[0] = polarity;
        write_cfg(CFG_ACTIVE_HIGH, cfg_word);
        phase_debounce = deb;
        ms_now = $urandom();
        burst_left = 0;
        for (int k = 0; k < n_items; k++)
            send_paced(next_random_req());
    endtask

    // Hold the result side off while requests keep coming, then drain
    task automatic test_backpressure();
        t_req rq;
        wait_drain();
        hold_request = 160;
        for (int k = 0; k < 60; k++) begin
            rq = next_random_req();
            send_req(rq.kind, rq.pins, rq.line_hit, rq.now_ms, rq.chan);
        end
        wait_drain();
        hold_request = 90;
        for (int k = 0; k < 60; k++)
            send_paced(next_random_req());
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_cfg_extremes();
        test_random_phase(300, DEB_RESET, 1'b1);
        test_random_phase(200, 16'd0, 1'b0);
        test_random_phase(200, 16'hFFFF, 1'b0);
        test_random_phase(250, 16'd3, 1'b1);
        test_random_phase(200, DEB_W'($urandom_range(1, 40)), 1'b0);
        test_backpressure();
        wait_drain();
        repeat (20) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never delivered",
                                      expected_results.size()));
        $display("Covered %0d requests (%0d pin, %0d poll, %0d consume, %0d init),",
                 kind_count[REQ_PIN] + kind_count[REQ_POLL] +
                 kind_count[REQ_CONSUME] + kind_count[REQ_INIT],
                 kind_count[REQ_PIN], kind_count[REQ_POLL], kind_count[REQ_CONSUME],
                 kind_count[REQ_INIT]);
        $display("%0d results checked, %0d debounce promotions, %0d stalled request cycles.",
                 results_checked, promotions, in_stall_cycles);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

>>> four_line_debounce_edge_counter.f
rtl/core/fldec_pkg.sv
rtl/core/fldec_cfg.sv
rtl/core/fldec_core.sv
rtl/core/four_line_debounce_edge_counter.sv
sim/tb_four_line_debounce_edge_counter.sv
